### rtl/core/fus_pkg.sv
// fus_pkg: shared types, constants and color helpers of the frame upscaler.
// Used by fus_front, fus_queue, fus_back and the top level of the upscaler core; depends on nothing.
`timescale 1ns / 1ps

package fus_pkg;

  // default frame geometry
  localparam int SRC_WIDTH_DEF  = 640;
  localparam int SRC_HEIGHT_DEF = 288;

  // field widths
  localparam int PIX_W      = 24;
  localparam int SCOL_W     = 10;
  localparam int SROW_W     = 9;
  localparam int DCOL_W     = 11;
  localparam int DROW_W     = 10;
  localparam int MODE_W     = 3;
  localparam int STEP_W     = 3;
  localparam int TDATA_W    = 48;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // scale mode codes; all other codes copy
  localparam logic [MODE_W-1:0] MODE_COPY       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_THREE_HALF = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WIDE       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TRIPLE     = 3'd5;

  // one classified source pixel waiting for expansion
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [SCOL_W-1:0] col;
    logic [SROW_W-1:0] row;
    logic [PIX_W-1:0]  nb;         // line above (mode 3) or left pixel (mode 4)
    logic [MODE_W-1:0] mode;
    logic [STEP_W-1:0] last_step;  // index of the final result of this pixel
  } q_entry_t;

  // per-channel average: red and green halve first, blue is an exact floor
  function automatic logic [PIX_W-1:0] avg_rgb(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [7:0] r;
    logic [7:0] g;
    logic [8:0] bs;
    r  = {1'b0, a[23:17]} + {1'b0, b[23:17]};
    g  = {1'b0, a[15:9]} + {1'b0, b[15:9]};
    bs = {1'b0, a[7:0]} + {1'b0, b[7:0]};
    return {r, g, bs[8:1]};
  endfunction

endpackage

### rtl/core/fus_ram.sv
// fus_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module fus_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 640
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/fus_front.sv
// fus_front: accepts source pixel beats, keeps the scale mode, line store and left pixel
// hold, and classifies each pixel into a queue entry. Depends on fus_pkg and fus_ram.
`timescale 1ns / 1ps

module fus_front import fus_pkg::*; #(
  parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = SRC_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [MODE_W-1:0]  cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [PIX_W-1:0]   pixel_color,
  input  logic [SCOL_W-1:0]  src_col,
  input  logic [SROW_W-1:0]  src_row,
  output logic               push_valid,
  input  logic               push_ready,
  output q_entry_t           push_data,
  output logic [MODE_W-1:0]  mode
);

  localparam int AW = $clog2(SRC_WIDTH);
  localparam logic [SCOL_W:0] COL_LIM = (SCOL_W + 1)'(SRC_WIDTH);
  localparam logic [SROW_W:0] ROW_LIM = (SROW_W + 1)'(SRC_HEIGHT);

  logic             accept;
  logic             in_frame;
  logic             produces;
  logic [STEP_W-1:0] last_step;
  logic             s1_valid;
  q_entry_t         s1;
  logic [PIX_W-1:0] hold;
  logic [PIX_W-1:0] above;

  // scale mode register; written only while idle is a rule for the user, the block does not enforce it
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_COPY;
    end else if (cfg_valid) begin
      mode <= cfg_data;
    end
  end

  // classify the incoming beat
  assign s_tready = !s1_valid || push_ready;
  assign accept   = s_tvalid && s_tready;
  assign in_frame = ({1'b0, src_col} < COL_LIM) && ({1'b0, src_row} < ROW_LIM);
  assign produces = in_frame && !(mode == MODE_WIDE && !src_col[0]);

  always_comb begin
    unique case (mode)
      MODE_DOUBLE:     last_step = 3'd1;
      MODE_THREE_HALF: last_step = src_row[0] ? 3'd1 : 3'd0;
      MODE_WIDE:       last_step = 3'd5;
      MODE_TRIPLE:     last_step = 3'd5;
      default:         last_step = 3'd0;
    endcase
  end

  // line store: even rows write, odd rows read the entry above
  fus_ram #(
    .WIDTH(PIX_W),
    .DEPTH(SRC_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (accept && in_frame && !src_row[0]),
    .waddr(src_col[AW-1:0]),
    .wdata(pixel_color),
    .re   (accept),
    .raddr(src_col[AW-1:0]),
    .rdata(above)
  );

  // left pixel hold, loaded on even columns
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
    end else if (accept && in_frame && !src_col[0]) begin
      hold <= pixel_color;
    end
  end

  // stage register waiting for the line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= produces;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.pixel     <= pixel_color;
      s1.col       <= src_col;
      s1.row       <= src_row;
      s1.nb        <= hold;
      s1.mode      <= mode;
      s1.last_step <= last_step;
    end
  end

  // hand the entry to the queue, taking the line above in mode 3
  assign push_valid = s1_valid;
  always_comb begin
    push_data = s1;
    if (s1.mode == MODE_THREE_HALF) begin
      push_data.nb = above;
    end
  end

endmodule

### rtl/core/fus_queue.sv
// fus_queue: short fifo of classified pixels between the front and the back.
// Depends on fus_pkg.
`timescale 1ns / 1ps

module fus_queue import fus_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_data,
  output logic     pop_valid,
  input  logic     pop,
  output q_entry_t pop_data
);

  q_entry_t       mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;
  logic           push_fire;
  logic           pop_fire;

  assign push_ready = count != (QAW + 1)'(QDEPTH);
  assign pop_valid  = count != '0;
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop && pop_valid;
  assign pop_data   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_fire) begin
        wptr <= wptr + 1'b1;
      end
      if (pop_fire) begin
        rptr <= rptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/fus_back.sv
// fus_back: steps through the destination pixels of the queue head, one per cycle while the
// output is not stalled, into the output register. Depends on fus_pkg.
`timescale 1ns / 1ps

module fus_back import fus_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  q_entry_t           q_head,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast,
  output logic [STEP_W-1:0]  step
);

  logic              load;
  logic              last;
  logic [DCOL_W-1:0] col;
  logic [DROW_W-1:0] row;
  logic [PIX_W-1:0]  color;
  logic [DCOL_W-1:0] c2;
  logic [DCOL_W-1:0] x3;
  logic [DROW_W-1:0] r2;
  logic [DCOL_W-1:0] r3;
  logic [DROW_W-1:0] k3;
  logic [1:0]        off;
  logic [PIX_W-1:0]  avg;

  assign load  = q_valid && (!m_tvalid || m_tready);
  assign last  = step == q_head.last_step;
  assign q_pop = load && last;

  // coordinate pieces
  assign c2  = {q_head.col, 1'b0};
  assign x3  = {2'b00, q_head.col[9:1]} + {1'b0, q_head.col[9:1], 1'b0};
  assign r2  = {q_head.row, 1'b0};
  assign r3  = {2'b00, q_head.row} + {1'b0, q_head.row, 1'b0};
  assign k3  = {2'b00, q_head.row[8:1]} + {1'b0, q_head.row[8:1], 1'b0};
  assign off = (step >= 3'd3) ? 2'(step - 3'd3) : step[1:0];
  assign avg = avg_rgb(q_head.nb, q_head.pixel);

  // destination pixel for the current step
  always_comb begin
    unique case (q_head.mode)
      MODE_DOUBLE: begin
        col   = {1'b0, q_head.col};
        row   = r2 | DROW_W'(step[0]);
        color = step[0] ? '0 : q_head.pixel;
      end
      MODE_THREE_HALF: begin
        col = {1'b0, q_head.col};
        if (!q_head.row[0]) begin
          row   = k3;
          color = q_head.pixel;
        end else begin
          row   = k3 + DROW_W'(step) + 1'b1;
          color = step[0] ? q_head.pixel : avg;
        end
      end
      MODE_WIDE: begin
        col = x3 + DCOL_W'(off);
        row = r2 | DROW_W'(step >= 3'd3);
        if (step >= 3'd3) begin
          color = '0;
        end else if (off == 2'd0) begin
          color = q_head.nb;
        end else if (off == 2'd1) begin
          color = avg;
        end else begin
          color = q_head.pixel;
        end
      end
      MODE_TRIPLE: begin
        col   = c2 | DCOL_W'(step[0]);
        row   = DROW_W'(r3 + DCOL_W'(step[2:1]));
        color = step[2] ? '0 : q_head.pixel;
      end
      default: begin
        col   = {1'b0, q_head.col};
        row   = {1'b0, q_head.row};
        color = q_head.pixel;
      end
    endcase
  end

  // step counter within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (load) begin
      step <= last ? '0 : step + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {3'b000, color, row, col};
      m_tlast <= last;
    end
  end

endmodule

### rtl/core/frame_upscaler_with_scanlines_core.sv
// frame_upscaler_with_scanlines_core: top level of the frame upscaler with scanlines.
// Depends on fus_pkg, fus_front, fus_queue, fus_back and fus_ram.
`timescale 1ns / 1ps

// Takes source pixels in raster order and emits the destination pixels of the selected
// scale mode with their coordinates, one result beat per cycle while the output is not stalled.
// A pixel yields one result in copy and mode 3 even rows, two in modes 2 and 3 odd rows, six
// in modes 4 and 5, none for mode 4 even columns and out-of-frame pixels. A pixel that is not
// stalled passes through the stage that waits for the line store read, which is loaded at the
// edge that accepts it, then through the queue, then into the output register.
// Input beats are taken while earlier pixels are still being expanded, until the
// four-entry queue fills. The line store is not cleared after reset. Change scale_mode
// only while no pixel is in flight.
module frame_upscaler_with_scanlines_core import fus_pkg::*; #(
  parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = SRC_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [MODE_W-1:0]  cfg_data,       // scale_mode
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // pixel_color[23:0], src_col[33:24], src_row[42:34]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // dest_col[10:0], dest_row[20:11], out_color[44:21]
  output logic               m_axis_tlast    // last_of_run
);

  logic              push_valid;
  logic              push_ready;
  q_entry_t          push_data;
  logic              q_valid;
  q_entry_t          q_head;
  logic              q_pop;
  logic [MODE_W-1:0] mode;
  logic [STEP_W-1:0] step;

  // accept and classify
  fus_front #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .pixel_color(s_axis_tdata[23:0]),
    .src_col    (s_axis_tdata[33:24]),
    .src_row    (s_axis_tdata[42:34]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .mode       (mode)
  );

  // decoupling queue
  fus_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_head)
  );

  // expand into destination beats
  fus_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .m_tvalid(m_axis_tvalid),
    .m_tready(m_axis_tready),
    .m_tdata (m_axis_tdata),
    .m_tlast (m_axis_tlast),
    .step    (step)
  );

`ifndef SYNTHESIS
  // the back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // the step counter stays within the head entry's results
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> step <= q_head.last_step)
    else $error("step counter beyond last result");

  // in scanline modes the last beat of a pixel is always a black row
  a_last_black: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast &&
     (mode == MODE_DOUBLE || mode == MODE_WIDE || mode == MODE_TRIPLE))
    |-> m_axis_tdata[44:21] == '0)
    else $error("last beat of a scanline mode is not black");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for frame_upscaler_with_scanlines_core, all scale modes.
// Depends on fus_pkg and the upscaler core RTL; predicts every destination beat itself.

module tb;
  import fus_pkg::*;

  // mode codes the package leaves unnamed; all of them copy
  localparam logic [MODE_W-1:0] MODE_ZERO   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_PIXELS  = 22;
  localparam int PAD_W         = TDATA_W - PIX_W - SCOL_W - SROW_W;
  localparam int SCOL_MAX      = (1 << SCOL_W) - 1;
  localparam int SROW_MAX      = (1 << SROW_W) - 1;

  typedef enum int {NOISE_COL_OUT, NOISE_ROW_OUT, NOISE_STRAY} noise_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0]  color;
    logic [SCOL_W-1:0] col;
    logic [SROW_W-1:0] row;
  } src_pixel_t;

  typedef struct packed {
    logic [DCOL_W-1:0] col;
    logic [DROW_W-1:0] row;
    logic [PIX_W-1:0]  color;
    logic              last;
  } dest_pixel_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [MODE_W-1:0]  cfg_data = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // pixel_color, src_col, src_row, zero pad
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // dest_col, dest_row, out_color, zero pad
  logic               m_axis_tlast;

  // pixels waiting to be offered, destination beats still owed by the block
  src_pixel_t  src_pixels_todo [$];
  dest_pixel_t dest_beats_due [$];

  // shadow of the block state
  logic [MODE_W-1:0] scale_mode_now = MODE_COPY;
  logic [PIX_W-1:0]  row_above_mem [SRC_WIDTH_DEF];
  logic [PIX_W-1:0]  left_pix = '0;

  // generator bookkeeping: line store entries already written, in-frame pixels queued
  bit line_filled [SRC_WIDTH_DEF];
  int framed_count = 0;

  int errors = 0;
  int src_gap = 0;
  int sink_gap = 0;
  bit calm = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  logic [MODE_W-1:0] phase_modes [10];

  frame_upscaler_with_scanlines_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  // per-channel mean: red and green halve each side, blue floors the exact sum
  function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    logic [7:0] red;
    logic [7:0] green;
    logic [8:0] blue_sum;
    red      = (a[23:16] >> 1) + (b[23:16] >> 1);
    green    = (a[15:8] >> 1) + (b[15:8] >> 1);
    blue_sum = 9'(a[7:0]) + 9'(b[7:0]);
    return {red, green, blue_sum[8:1]};
  endfunction

  function automatic dest_pixel_t dest_beat(input int col, input int row,
                                            input logic [PIX_W-1:0] color);
    dest_pixel_t d;
    d.col   = col[DCOL_W-1:0];
    d.row   = row[DROW_W-1:0];
    d.color = color;
    d.last  = 1'b0;
    return d;
  endfunction

  function automatic string show(input dest_pixel_t d);
    return $sformatf("(col %0d, row %0d, color %06h, last %0b)", d.col, d.row, d.color, d.last);
  endfunction

  function automatic void flag(input string what);
    errors++;
    if (errors <= 10) $display("mismatch: %s", what);
  endfunction

  function automatic logic [PIX_W-1:0] rand_color();
    logic [31:0] v;
    v = $urandom();
    return v[PIX_W-1:0];
  endfunction

  // expand one accepted pixel into the beats the current mode owes for it
  task automatic expand_pixel(input src_pixel_t px);
    dest_pixel_t run [$];
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] left;
    int c;
    int r;
    int x;
    c = int'(px.col);
    r = int'(px.row);
    above = '0;
    left = left_pix;
    if (c >= SRC_WIDTH_DEF || r >= SRC_HEIGHT_DEF) return;
    // store updates happen in every mode
    if (r % 2 == 0) row_above_mem[c] = px.color;
    else above = row_above_mem[c];
    if (c % 2 == 0) left_pix = px.color;
    case (scale_mode_now)
      MODE_DOUBLE: begin
        run.push_back(dest_beat(c, 2 * r, px.color));
        run.push_back(dest_beat(c, 2 * r + 1, '0));
      end
      MODE_THREE_HALF: begin
        if (r % 2 == 0) begin
          run.push_back(dest_beat(c, 3 * (r / 2), px.color));
        end else begin
          run.push_back(dest_beat(c, 3 * (r / 2) + 1, blend(above, px.color)));
          run.push_back(dest_beat(c, 3 * (r / 2) + 2, px.color));
        end
      end
      MODE_WIDE: begin
        if (c % 2 == 1) begin
          x = 3 * (c / 2);
          run.push_back(dest_beat(x, 2 * r, left));
          run.push_back(dest_beat(x + 1, 2 * r, blend(left, px.color)));
          run.push_back(dest_beat(x + 2, 2 * r, px.color));
          run.push_back(dest_beat(x, 2 * r + 1, '0));
          run.push_back(dest_beat(x + 1, 2 * r + 1, '0));
          run.push_back(dest_beat(x + 2, 2 * r + 1, '0));
        end
      end
      MODE_TRIPLE: begin
        run.push_back(dest_beat(2 * c, 3 * r, px.color));
        run.push_back(dest_beat(2 * c + 1, 3 * r, px.color));
        run.push_back(dest_beat(2 * c, 3 * r + 1, px.color));
        run.push_back(dest_beat(2 * c + 1, 3 * r + 1, px.color));
        run.push_back(dest_beat(2 * c, 3 * r + 2, '0));
        run.push_back(dest_beat(2 * c + 1, 3 * r + 2, '0));
      end
      default: begin
        run.push_back(dest_beat(c, r, px.color));
      end
    endcase
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) dest_beats_due.push_back(run[i]);
  endtask

  // source driver: accepts, predicts, then offers the next pixel or idles
  always @(posedge clk) begin : src_driver
    bit offer;
    if (!rst && s_axis_tvalid && s_axis_tready) expand_pixel(src_pixels_todo.pop_front());
    offer = 1'b0;
    if (rst) begin
      offer = 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      offer = 1'b1;
    end else if (src_gap > 0) begin
      src_gap--;
    end else if (src_pixels_todo.size() > 0) begin
      if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 16) - 1;
      else offer = 1'b1;
    end
    s_axis_tvalid <= offer;
    if (offer)
      s_axis_tdata <= {{PAD_W{1'b0}}, src_pixels_todo[0].row, src_pixels_todo[0].col,
                       src_pixels_todo[0].color};
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin : sink_hold
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  // result monitor: compares each beat with the oldest prediction, drives tready
  always @(posedge clk) begin : dest_monitor
    dest_pixel_t got;
    dest_pixel_t want;
    bit ready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.col   = m_axis_tdata[DCOL_W-1:0];
      got.row   = m_axis_tdata[DCOL_W+DROW_W-1:DCOL_W];
      got.color = m_axis_tdata[DCOL_W+DROW_W+PIX_W-1:DCOL_W+DROW_W];
      got.last  = m_axis_tlast;
      if (dest_beats_due.size() == 0) begin
        flag($sformatf("beat with nothing owed %s", show(got)));
      end else begin
        want = dest_beats_due.pop_front();
        if (got.col !== want.col || got.row !== want.row ||
            got.color !== want.color || got.last !== want.last)
          flag($sformatf("expected %s got %s", show(want), show(got)));
      end
    end
    ready = 1'b1;
    if (hold_left > 0) begin
      ready = 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      ready = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 16) - 1;
      ready = 1'b0;
    end
    m_axis_tready <= ready;
  end

  task automatic queue_pixel(input logic [PIX_W-1:0] color, input int col, input int row);
    src_pixel_t px;
    px.color = color;
    px.col   = col[SCOL_W-1:0];
    px.row   = row[SROW_W-1:0];
    src_pixels_todo.push_back(px);
    if (col < SRC_WIDTH_DEF && row < SRC_HEIGHT_DEF) begin
      framed_count++;
      if (row % 2 == 0) line_filled[col] = 1'b1;
    end
  endtask

  // wait until nothing is queued or owed, then let the pipeline settle
  task automatic wait_drained();
    do @(negedge clk);
    while (src_pixels_todo.size() != 0 || s_axis_tvalid || dest_beats_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    scale_mode_now = m;
    @(negedge clk);
  endtask

  // mostly row-pair fragments over even column pairs, the rest stray pixels
  task automatic random_phase(input int target);
    int goal;
    int r0;
    int c0;
    int ncols;
    int col;
    int row;
    noise_kind_t kind;
    goal = framed_count + target;
    while (framed_count < goal) begin
      if ($urandom_range(0, 1) == 0) begin
        r0 = 2 * $urandom_range(0, SRC_HEIGHT_DEF / 2 - 1);
        c0 = 2 * $urandom_range(0, SRC_WIDTH_DEF / 2 - 1);
        ncols = 2 * $urandom_range(1, 4);
        if (c0 + ncols > SRC_WIDTH_DEF) ncols = SRC_WIDTH_DEF - c0;
        for (int rr = 0; rr < 2; rr++)
          for (int cc = 0; cc < ncols; cc++) queue_pixel(rand_color(), c0 + cc, r0 + rr);
      end else begin
        kind = noise_kind_t'($urandom_range(0, 2));
        case (kind)
          NOISE_COL_OUT: begin
            col = $urandom_range(SRC_WIDTH_DEF, SCOL_MAX);
            row = $urandom_range(0, SROW_MAX);
          end
          NOISE_ROW_OUT: begin
            col = $urandom_range(0, SCOL_MAX);
            row = $urandom_range(SRC_HEIGHT_DEF, SROW_MAX);
          end
          default: begin
            col = $urandom_range(0, SRC_WIDTH_DEF - 1);
            row = $urandom_range(0, SRC_HEIGHT_DEF - 1);
            // never read a line store entry that was not written
            if (row % 2 == 1 && !line_filled[col]) row = row - 1;
          end
        endcase
        queue_pixel(rand_color(), col, row);
      end
    end
  endtask

  initial begin : stimulus
    bit held;
    held = 1'b0;
    phase_modes = '{MODE_THREE_HALF, MODE_WIDE, MODE_TRIPLE, MODE_DOUBLE, MODE_SPARE7,
                    MODE_THREE_HALF, MODE_WIDE, MODE_ZERO, MODE_TRIPLE, MODE_COPY};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset mode copies; odd columns only so the left hold keeps its reset value
    queue_pixel(24'hFFFFFF, 1, 0);
    queue_pixel(24'h000000, SRC_WIDTH_DEF - 1, SRC_HEIGHT_DEF - 1);
    queue_pixel(24'h123456, SCOL_MAX, 5);
    queue_pixel(24'hABCDEF, 3, SROW_MAX);
    wait_drained();

    // wide: first pair uses the zero hold, extreme averages, far corner, unpaired column
    set_mode(MODE_WIDE);
    queue_pixel(24'h808080, 1, 0);
    queue_pixel(24'hFFFFFF, 0, 2);
    queue_pixel(24'hFFFFFF, 1, 2);
    queue_pixel(24'h010101, SRC_WIDTH_DEF - 2, SRC_HEIGHT_DEF - 1);
    queue_pixel(24'hFF00FF, SRC_WIDTH_DEF - 1, SRC_HEIGHT_DEF - 1);
    queue_pixel(24'h55AA33, 0, 4);
    wait_drained();

    // one-and-half height: row pairs with rounding corners of the blend
    set_mode(MODE_THREE_HALF);
    queue_pixel(24'hFFFFFF, 0, 0);
    queue_pixel(24'hFFFFFF, 0, 1);
    queue_pixel(24'h000001, 5, 0);
    queue_pixel(24'h0000FF, 5, 1);
    queue_pixel(24'h01FF01, SRC_WIDTH_DEF - 1, SRC_HEIGHT_DEF - 2);
    queue_pixel(24'hFE00FF, SRC_WIDTH_DEF - 1, SRC_HEIGHT_DEF - 1);
    wait_drained();

    set_mode(MODE_TRIPLE);
    queue_pixel(24'hFFFFFF, SRC_WIDTH_DEF - 1, SRC_HEIGHT_DEF - 1);
    queue_pixel(24'h000000, 0, 0);
    wait_drained();

    set_mode(MODE_DOUBLE);
    queue_pixel(24'h112233, SRC_WIDTH_DEF - 1, SRC_HEIGHT_DEF - 1);
    queue_pixel(24'hFFFFFF, 0, 0);
    wait_drained();

    // unused codes behave as copy
    set_mode(MODE_ZERO);
    queue_pixel(24'hC0FFEE, 2, 3);
    wait_drained();
    set_mode(MODE_SPARE6);
    queue_pixel(24'h123456, 4, 6);
    wait_drained();
    set_mode(MODE_SPARE7);
    queue_pixel(24'hFEDCBA, SRC_WIDTH_DEF - 2, SRC_HEIGHT_DEF - 2);
    wait_drained();

    // random phases; the last one runs without idling
    foreach (phase_modes[i]) begin
      if (i == 9) calm = 1'b1;
      set_mode(phase_modes[i]);
      if (phase_modes[i] == MODE_TRIPLE && !held) begin
        // receiver holds off while the sender keeps pushing
        hold_requests++;
        held = 1'b1;
      end
      random_phase(PHASE_PIXELS);
      wait_drained();
    end

    if (errors == 0 && dest_beats_due.size() == 0) begin
      $display("frame_upscaler_with_scanlines_core verification clean");
    end else begin
      $display("frame_upscaler_with_scanlines_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("frame_upscaler_with_scanlines_core verification failed");
    $finish;
  end

endmodule
